// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files of the modular exponentiation core.
// Every macro samples on clk and stays quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define MEXP_IMPLIES(lbl, ante, cons, msg) `MEXP_ASSERT(lbl, (ante) |-> (cons), msg)

// Check that a condition implies another in the following cycle.
`define MEXP_NEXT(lbl, ante, cons, msg) `MEXP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/mexp_pkg.sv =====
// Shared types and constants of the modular exponentiation core.
// No dependencies; the interfaces and the top level import it.
package mexp_pkg;

  // Width of every operand and result field on the channels
  localparam int FIELD_WIDTH = 64;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_FINISH
  } mexp_state_t;

endpackage

// ===== rtl/core/mexp_in_if.sv =====
// Input channel of the modular exponentiation core: valid/ready plus operands.
// Depends on mexp_pkg for the field width.
interface mexp_in_if import mexp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] base_value;
  logic [FIELD_WIDTH-1:0] exponent;
  logic [FIELD_WIDTH-1:0] modulus;

  modport source (output valid, output base_value, output exponent, output modulus,
                  input ready);
  modport sink   (input valid, input base_value, input exponent, input modulus,
                  output ready);
endinterface

// ===== rtl/core/mexp_out_if.sv =====
// Output channel of the modular exponentiation core: valid/ready plus result.
// Depends on mexp_pkg for the field width.
interface mexp_out_if import mexp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] power_result;
  logic                   modulus_error;

  modport source (output valid, output power_result, output modulus_error, input ready);
  modport sink   (input valid, input power_result, input modulus_error, output ready);
endinterface

// ===== rtl/core/modular_exponentiation_core.sv =====
// Modular exponentiation core: computes base_value ** exponent mod modulus by
// right-to-left square-and-multiply on OPERAND_WIDTH-bit operands (inputs are cut to
// their low OPERAND_WIDTH bits). Each word is accepted in ST_IDLE, its base is reduced in
// ST_REDUCE, one ST_MUL pass runs for every exponent bit up to its highest set bit, and
// ST_FINISH hands the result to the output register, waiting while an untaken result
// still sits there. A zero modulus (error flag, result 0) or a zero exponent (result 1)
// goes from ST_IDLE straight to ST_FINISH. The two bit-serial modular multipliers take
// one multiplier bit per cycle, square and multiply side by side. One word is in work
// at a time; a new word is accepted while the previous result waits in the output
// register.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if and assert_macros.svh.
`include "assert_macros.svh"

module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  mexp_in_if.sink   in_chan,
  mexp_out_if.source out_chan
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

  // One interleaved shift-add step: (2 * acc + addend) mod m, for acc, addend < m
  function automatic logic [W-1:0] step_mod(input logic [W-1:0] acc,
                                            input logic [W-1:0] addend,
                                            input logic [W-1:0] m);
    logic [W+1:0] t;
    logic [W+1:0] m1;
    logic [W+1:0] m2;
    logic [W+1:0] d1;
    logic [W+1:0] d2;
    t  = {1'b0, acc, 1'b0} + {2'b00, addend};
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    d1 = t - m1;
    d2 = t - m2;
    if (t >= m2) begin
      step_mod = d2[W-1:0];
    end else if (t >= m1) begin
      step_mod = d1[W-1:0];
    end else begin
      step_mod = t[W-1:0];
    end
  endfunction

  mexp_state_t   state;
  mexp_state_t   state_next;
  logic [CW-1:0] cnt;
  logic [W-1:0]  m_reg;
  logic [W-1:0]  b_reg;
  logic [W-1:0]  e_reg;
  logic [W-1:0]  r_reg;
  logic [W-1:0]  mq;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  acc_s;
  logic          err_reg;
  logic          out_valid;

  logic          accept;
  logic          load_out;
  logic          pass_end;
  logic          mbit;
  logic          exp_done;
  logic [W-1:0]  in_base;
  logic [W-1:0]  in_exp;
  logic [W-1:0]  in_mod;
  logic [W-1:0]  addend_r;
  logic [W-1:0]  addend_s;
  logic [W-1:0]  acc_r_next;
  logic [W-1:0]  acc_s_next;
  logic          residue_ok;
  logic          zero_mod_in;
  logic          err_word;

  // Cut the operands to the working width
  assign in_base = in_chan.base_value[W-1:0];
  assign in_exp  = in_chan.exponent[W-1:0];
  assign in_mod  = in_chan.modulus[W-1:0];

  assign accept   = in_chan.valid && in_chan.ready;
  assign pass_end = (cnt == '0);
  assign mbit     = mq[W-1];
  assign exp_done = (e_reg[W-1:1] == '0);

  // Multiplier datapaths: unit R forms r * b, unit S forms b * b or reduces the base
  assign addend_r = mbit ? r_reg : '0;
  assign addend_s = (state == ST_REDUCE) ? {{(W-1){1'b0}}, mbit} : (mbit ? b_reg : '0);
  assign acc_r_next = step_mod(acc_r, addend_r, m_reg);
  assign acc_s_next = step_mod(acc_s, addend_s, m_reg);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_mod == '0 || in_exp == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (pass_end) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (pass_end && exp_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_chan.ready = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE:   in_chan.ready = 1'b1;
      ST_FINISH: load_out = !out_valid || out_chan.ready;
      default: begin
        in_chan.ready = 1'b0;
        load_out      = 1'b0;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load operands, run the bit-serial passes, advance the exponent
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          m_reg   <= in_mod;
          e_reg   <= in_exp;
          mq      <= in_base;
          acc_s   <= '0;
          cnt     <= LAST_BIT;
          err_reg <= (in_mod == '0);
          if (in_mod == '0) begin
            r_reg <= '0;
          end else if (in_exp == '0) begin
            r_reg <= {{(W-1){1'b0}}, 1'b1};
          end else begin
            r_reg <= {{(W-1){1'b0}}, (in_mod != {{(W-1){1'b0}}, 1'b1})};
          end
        end
      end
      ST_REDUCE: begin
        acc_s <= acc_s_next;
        mq    <= {mq[W-2:0], 1'b0};
        cnt   <= cnt - CW'(1);
        if (pass_end) begin
          b_reg <= acc_s_next;
          mq    <= acc_s_next;
          acc_s <= '0;
          acc_r <= '0;
          cnt   <= LAST_BIT;
        end
      end
      ST_MUL: begin
        acc_r <= acc_r_next;
        acc_s <= acc_s_next;
        mq    <= {mq[W-2:0], 1'b0};
        cnt   <= cnt - CW'(1);
        if (pass_end) begin
          if (e_reg[0]) begin
            r_reg <= acc_r_next;
          end
          b_reg <= acc_s_next;
          mq    <= acc_s_next;
          e_reg <= {1'b0, e_reg[W-1:1]};
          acc_s <= '0;
          acc_r <= '0;
          cnt   <= LAST_BIT;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_chan.power_result  <= FIELD_WIDTH'(r_reg);
      out_chan.modulus_error <= err_reg;
    end
  end

  assign out_chan.valid = out_valid;

  // Terms for the checks below
  assign residue_ok  = acc_r < m_reg && acc_s < m_reg && b_reg < m_reg && r_reg < m_reg;
  assign zero_mod_in = accept && in_mod == '0;
  assign err_word    = out_valid && out_chan.modulus_error;

  // Residues stay below the modulus while multiplying
  `MEXP_IMPLIES(a_residue_range, state == ST_MUL, residue_ok, "residue not below modulus")
  // A zero modulus skips the passes
  `MEXP_NEXT(a_zero_mod_skip, zero_mod_in, state == ST_FINISH && err_reg, "zero modulus missed")
  // An error word carries a zero result
  `MEXP_IMPLIES(a_error_result, err_word, out_chan.power_result == '0, "nonzero error result")
  // No new word while a result waits in the sequencer
  `MEXP_IMPLIES(a_one_in_flight, state != ST_IDLE, !in_chan.ready, "ready raised while busy")

endmodule
